### hdl/cstd_pkg.sv
// Package for the CAN signal table decoder: sizes, codes, word layouts and states.
package cstd_pkg;

  localparam int SIGNAL_SLOTS = 64;
  localparam int FRAME_BYTES  = 8;

  localparam int SLOT_AW = (SIGNAL_SLOTS > 1) ? $clog2(SIGNAL_SLOTS) : 1;
  localparam int CNT_W   = $clog2(SIGNAL_SLOTS + 1);
  localparam int ID_W    = 29;
  localparam int DATA_W  = 64;
  localparam int LEN_W   = 4;
  localparam int FAC_W   = 32;
  localparam int OFF_W   = 64;
  localparam int PROD_W  = 65;
  localparam int ACC_W   = 98;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_WALK,
    ST_FETCH,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ACC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                    command;
    logic [5:0]              entry_index;
    logic                    entry_valid;
    logic [ID_W-1:0]         message_id;
    logic [5:0]              start_bit;
    logic [6:0]              bit_length;
    logic                    intel_order;
    logic signed [FAC_W-1:0] scale_factor;
    logic signed [OFF_W-1:0] scale_offset;
    logic [DATA_W-1:0]       frame_data;
    logic [LEN_W-1:0]        data_length;
  } in_word_t;

  typedef struct packed {
    logic [5:0]              signal_index;
    logic [DATA_W-1:0]       raw_value;
    logic signed [OFF_W-1:0] physical_value;
    logic                    saturated;
    logic                    last_signal;
  } out_word_t;

  typedef struct packed {
    logic       intel;
    logic [6:0] length;
    logic [5:0] start;
  } layout_t;

  typedef struct packed {
    layout_t          layout;
    logic [FAC_W-1:0] factor;
    logic [OFF_W-1:0] offset;
  } param_word_t;

endpackage

### hdl/cstd_in_if.sv
// Input channel of the decoder: valid, ready and one command word.
interface cstd_in_if import cstd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/cstd_out_if.sv
// Output channel of the decoder: valid, ready and one result word.
interface cstd_out_if import cstd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/cstd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cstd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/cstd_field_extract.sv
// Bit field extraction from a frame in Intel or Motorola numbering.
module cstd_field_extract import cstd_pkg::*; (
  input  logic [DATA_W-1:0] data_i,
  input  layout_t           layout_i,
  output logic [DATA_W-1:0] raw_o
);

  logic              len_ok;
  logic [DATA_W-1:0] mask;
  logic [DATA_W-1:0] swapped;
  logic [5:0]        be_start;
  logic [7:0]        be_end;
  logic [6:0]        rsh;
  logic [DATA_W-1:0] moto;
  logic [DATA_W-1:0] intel;

  always_comb begin
    len_ok = (layout_i.length != 7'd0) && (layout_i.length <= 7'd64);
    mask   = layout_i.length[6] ? {DATA_W{1'b1}}
                                : ~({DATA_W{1'b1}} << layout_i.length[5:0]);

    // Motorola fields run upward in big-endian bit numbering, so the byte
    // swapped frame holds them as one contiguous run with the MSB on top.
    for (int k = 0; k < 8; k++) begin
      swapped[8*k +: 8] = data_i[8*(7-k) +: 8];
    end
    be_start = {layout_i.start[5:3], ~layout_i.start[2:0]};
    be_end   = {2'b00, be_start} + {1'b0, layout_i.length};
    rsh      = 7'(8'd64 - be_end);
    if (be_end <= 8'd64) begin
      moto = swapped >> rsh;
    end else begin
      // The field runs past the last byte; missing bits read as zero.
      moto = swapped << be_end[5:0];
    end

    intel = data_i >> layout_i.start;

    if (!len_ok) begin
      raw_o = '0;
    end else if (layout_i.intel) begin
      raw_o = intel & mask;
    end else begin
      raw_o = moto & mask;
    end
  end

endmodule

### hdl/can_signal_table_decoder.sv
// Top level of the CAN signal table decoder: descriptor table, scan, extract and scale.
//
//   channel | dir | word         | accepted when
//   --------+-----+--------------+-----------------------------
//   in_i    | in  | in_word_t    | in_i.valid && in_i.ready
//   out_o   | out | out_word_t   | out_o.valid && out_o.ready
//
// A load word is taken while idle and writes one table slot. A decode word
// is accepted, scanned against the id RAM one slot a cycle (a final state
// finishes the last compare), then walked slot by slot up to the last matching
// one; each matching slot passes fetch, a low and a high multiply step,
// accumulate and emit, as the shared multiplier is used twice per signal.
// Reset clears the valid bits and the sequencer at once; no clearing pass.
// A held result stalls the walk only when the next result is ready; the last
// result of a frame may wait in the output register while new words are taken.
module can_signal_table_decoder import cstd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  cstd_in_if.sink     in_i,
  cstd_out_if.source  out_o
);

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SIGNAL_SLOTS - 1);

  // Sequencer and control state.
  state_e              state_q, state_d;
  logic [SLOT_AW-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SIGNAL_SLOTS-1:0] valid_q, valid_d;
  logic [SIGNAL_SLOTS-1:0] mask_q, mask_d;
  logic                cmp_vld_q;
  logic                out_valid_q, out_valid_d;

  // Payload registers.
  logic [SLOT_AW-1:0]      cmp_idx_q;
  logic [ID_W-1:0]         frame_id_q;
  logic [DATA_W-1:0]       data_q, data_d;
  logic [DATA_W-1:0]       raw_q;
  logic signed [FAC_W-1:0] factor_q;
  logic signed [OFF_W-1:0] offset_q;
  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_q;
  out_word_t               out_q, out_d;

  // Handshake and control terms.
  logic              in_ready;
  logic              take;
  logic              slot_ok;
  logic              load_go;
  logic              dec_go;
  logic              out_free;
  logic              emit;
  logic              hit;
  logic [SLOT_AW-1:0] waddr;
  logic [LEN_W-1:0]  len_c;

  // Table read data and extraction.
  logic [ID_W-1:0]   id_rdata;
  param_word_t       par_wdata;
  param_word_t       par_rdata;
  logic [DATA_W-1:0] raw_ext;

  // Scaling terms.
  logic [31:0]              mul_a;
  logic signed [32:0]       mul_a_ext;
  logic signed [32:0]       fac_ext;
  logic signed [65:0]       mul_p;
  logic                     fits;
  logic [OFF_W-1:0]         phys;

  // Id RAM: read in the scan, one slot a cycle.
  cstd_ram #(
    .WIDTH (ID_W),
    .DEPTH (SIGNAL_SLOTS)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (load_go),
    .waddr_i (waddr),
    .wdata_i (in_i.data.message_id),
    .raddr_i (idx_q),
    .rdata_o (id_rdata)
  );

  // Descriptor RAM: layout, factor and offset, read once per matching slot.
  assign par_wdata.layout.intel  = in_i.data.intel_order;
  assign par_wdata.layout.length = in_i.data.bit_length;
  assign par_wdata.layout.start  = in_i.data.start_bit;
  assign par_wdata.factor        = in_i.data.scale_factor;
  assign par_wdata.offset        = in_i.data.scale_offset;

  cstd_ram #(
    .WIDTH ($bits(param_word_t)),
    .DEPTH (SIGNAL_SLOTS)
  ) u_par_ram (
    .clk_i   (clk_i),
    .we_i    (load_go),
    .waddr_i (waddr),
    .wdata_i (par_wdata),
    .raddr_i (idx_q),
    .rdata_o (par_rdata)
  );

  cstd_field_extract u_extract (
    .data_i   (data_q),
    .layout_i (par_rdata.layout),
    .raw_o    (raw_ext)
  );

  // Sequencer outputs.
  always_comb begin
    in_ready = (state_q == ST_IDLE);
    take     = in_ready && in_i.valid;
    slot_ok  = ({1'b0, in_i.data.entry_index} < 7'(SIGNAL_SLOTS));
    load_go  = take && (in_i.data.command == CMD_LOAD) && slot_ok;
    dec_go   = take && (in_i.data.command == CMD_DECODE);
    out_free = !out_valid_q || out_o.ready;
    emit     = (state_q == ST_EMIT) && out_free;
    waddr    = in_i.data.entry_index[SLOT_AW-1:0];
    // A slot matches when it is in use and owns the frame id.
    hit      = cmp_vld_q && valid_q[cmp_idx_q] && (id_rdata == frame_id_q);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (dec_go) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_q == LAST_SLOT) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ((cnt_q == '0) && !hit) ? ST_IDLE : ST_WALK;
      end
      ST_WALK: begin
        if (mask_q[idx_q]) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH:  state_d = ST_MUL_LO;
      ST_MUL_LO: state_d = ST_MUL_HI;
      ST_MUL_HI: state_d = ST_ACC;
      ST_ACC:    state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_WALK;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and datapath next values.
  always_comb begin
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    valid_d     = valid_q;
    mask_d      = mask_q;
    data_d      = data_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    // Bytes at or past the frame length are stored as zero.
    len_c = (in_i.data.data_length > LEN_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES)
                                                          : in_i.data.data_length;

    if (load_go) begin
      valid_d[waddr] = in_i.data.entry_valid;
    end

    if (dec_go) begin
      idx_d  = '0;
      cnt_d  = '0;
      mask_d = '0;
      for (int k = 0; k < 8; k++) begin
        data_d[8*k +: 8] = ((LEN_W'(k) < len_c) && (k < FRAME_BYTES))
                           ? in_i.data.frame_data[8*k +: 8] : 8'h00;
      end
    end

    if (state_q == ST_SCAN) begin
      idx_d = (idx_q == LAST_SLOT) ? '0 : idx_q + SLOT_AW'(1);
    end

    // The compare is made in the cycle after the id read.
    if (cmp_vld_q) begin
      mask_d[cmp_idx_q] = hit;
      cnt_d             = cnt_q + CNT_W'(hit);
    end

    if ((state_q == ST_WALK) && !mask_q[idx_q]) begin
      idx_d = idx_q + SLOT_AW'(1);
    end

    // Clip the exact sum to the signed 64-bit range.
    fits = (acc_q[ACC_W-1:OFF_W-1] == '0) || (acc_q[ACC_W-1:OFF_W-1] == '1);
    if (fits) begin
      phys = acc_q[OFF_W-1:0];
    end else if (acc_q[ACC_W-1]) begin
      phys = {1'b1, {(OFF_W-1){1'b0}}};
    end else begin
      phys = {1'b0, {(OFF_W-1){1'b1}}};
    end

    if (emit) begin
      out_d.signal_index   = 6'(idx_q);
      out_d.raw_value      = raw_q;
      out_d.physical_value = phys;
      out_d.saturated      = !fits;
      out_d.last_signal    = (cnt_q == CNT_W'(1));
      out_valid_d          = 1'b1;
      cnt_d                = cnt_q - CNT_W'(1);
      idx_d                = idx_q + SLOT_AW'(1);
    end
  end

  // The shared multiplier takes the low and then the high half of the raw
  // value against the signed factor, 33 by 33 bits signed.
  always_comb begin
    mul_a     = (state_q == ST_MUL_LO) ? raw_q[31:0] : raw_q[63:32];
    mul_a_ext = $signed({1'b0, mul_a});
    fac_ext   = $signed({factor_q[FAC_W-1], factor_q});
    mul_p     = mul_a_ext * fac_ext;
    prod_d    = mul_p[PROD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      cnt_q       <= '0;
      valid_q     <= '0;
      mask_q      <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      mask_q      <= mask_d;
      cmp_vld_q   <= (state_q == ST_SCAN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q <= idx_q;
    data_q    <= data_d;
    out_q     <= out_d;
    prod_q    <= prod_d;
    if (dec_go) begin
      frame_id_q <= in_i.data.message_id;
    end
    if (state_q == ST_FETCH) begin
      raw_q    <= raw_ext;
      factor_q <= $signed(par_rdata.factor);
      offset_q <= $signed(par_rdata.offset);
    end
    if (state_q == ST_MUL_HI) begin
      // Low partial product plus the offset, both sign extended.
      acc_q <= $signed({{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q})
             + $signed({{(ACC_W-OFF_W){offset_q[OFF_W-1]}}, offset_q});
    end else if (state_q == ST_ACC) begin
      // High partial product enters 32 bits up.
      acc_q <= acc_q
             + $signed({{(ACC_W-PROD_W-32){prod_q[PROD_W-1]}}, prod_q, 32'b0});
    end
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

endmodule
